/* rtl/rmm_pkg.sv */
// ----------------------------------------------------------------------------
// rmm_pkg
// Shared types and constants for the range min/max spread tree.
// ----------------------------------------------------------------------------
package rmm_pkg;
  localparam int Capacity   = 1024;
  localparam int ValueBits  = 31;
  localparam int PosBits    = 11;
  localparam int NodeBits   = $clog2(2 * Capacity);
  localparam int NodeCount  = 2 * Capacity;

  typedef logic [ValueBits-1:0] value_t;
  typedef logic [NodeBits-1:0]  node_t;
  typedef logic [PosBits-1:0]   pos_t;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_WRITE,
    ST_UPD_READ,
    ST_UPD_WAIT,
    ST_UPD_FIX,
    ST_QRY_STEP,
    ST_QRY_READ,
    ST_QRY_WAIT,
    ST_QRY_TAKE,
    ST_QRY_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear_write;
    logic load;
    logic leaf_write;
    logic read_left;
    logic read_right;
    logic fix_write;
    logic climb;
    logic qry_read;
    logic qry_take;
    logic qry_shift;
    logic result;
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_last;
    logic upd_ok;
    logic at_root;
    logic qry_live;
    logic l_odd;
    logic r_odd;
    logic qry_pick_l;
  } stat_t;
endpackage

/* rtl/rmm_ram.sv */
// ----------------------------------------------------------------------------
// rmm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module rmm_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // write or read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/rmm_ctrl.sv */
// ----------------------------------------------------------------------------
// rmm_ctrl
// Sequencer for clearing, updates and queries.
// ----------------------------------------------------------------------------
module rmm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           command,
  input  rmm_pkg::stat_t stat,
  output rmm_pkg::ctrl_t ctrl,
  output logic           busy
);
  rmm_pkg::state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // pick next state and commands
  always_comb begin
    state_next = state;
    ctrl = '0;
    busy = 1'b1;
    case (state)
      rmm_pkg::ST_CLEAR: begin
        ctrl.clear_write = 1'b1;
        if (stat.clear_last) begin
          state_next = rmm_pkg::ST_IDLE;
        end
      end
      rmm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load = 1'b1;
          state_next = (command == rmm_pkg::CMD_QUERY) ? rmm_pkg::ST_QRY_STEP
                                                       : rmm_pkg::ST_UPD_WRITE;
        end
      end
      rmm_pkg::ST_UPD_WRITE: begin
        if (stat.upd_ok) begin
          ctrl.leaf_write = 1'b1;
          state_next = rmm_pkg::ST_UPD_READ;
        end else begin
          state_next = rmm_pkg::ST_IDLE;
        end
      end
      rmm_pkg::ST_UPD_READ: begin
        if (stat.at_root) begin
          state_next = rmm_pkg::ST_IDLE;
        end else begin
          ctrl.read_left = 1'b1;
          state_next = rmm_pkg::ST_UPD_WAIT;
        end
      end
      rmm_pkg::ST_UPD_WAIT: begin
        ctrl.read_right = 1'b1;
        state_next = rmm_pkg::ST_UPD_FIX;
      end
      rmm_pkg::ST_UPD_FIX: begin
        ctrl.fix_write = 1'b1;
        ctrl.climb = 1'b1;
        state_next = rmm_pkg::ST_UPD_READ;
      end
      rmm_pkg::ST_QRY_STEP: begin
        if (!stat.qry_live) begin
          state_next = rmm_pkg::ST_QRY_DONE;
        end else if (stat.l_odd || stat.r_odd) begin
          ctrl.qry_read = 1'b1;
          state_next = rmm_pkg::ST_QRY_WAIT;
        end else begin
          ctrl.qry_shift = 1'b1;
        end
      end
      rmm_pkg::ST_QRY_WAIT: begin
        // keep the node address on the port so the read word stays put
        ctrl.qry_read = 1'b1;
        state_next = rmm_pkg::ST_QRY_TAKE;
      end
      rmm_pkg::ST_QRY_TAKE: begin
        ctrl.qry_take = 1'b1;
        state_next = rmm_pkg::ST_QRY_STEP;
      end
      rmm_pkg::ST_QRY_DONE: begin
        ctrl.result = 1'b1;
        state_next = rmm_pkg::ST_IDLE;
      end
      default: begin
        state_next = rmm_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

/* rtl/rmm_dp.sv */
// ----------------------------------------------------------------------------
// rmm_dp
// Datapath: tree memories, node pointers and the running min/max.
// ----------------------------------------------------------------------------
module rmm_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  rmm_pkg::ctrl_t        ctrl,
  output rmm_pkg::stat_t        stat,
  input  logic                  cfg_we,
  input  logic [10:0]           cfg_data,
  input  logic [10:0]           position,
  input  logic [30:0]           value,
  input  logic [10:0]           first_position,
  input  logic [10:0]           last_position,
  output logic                  result_valid,
  output logic [30:0]           range_min,
  output logic [30:0]           range_max,
  output logic [30:0]           spread,
  output logic                  range_empty
);
  localparam int NB = rmm_pkg::NodeBits;
  localparam int VB = rmm_pkg::ValueBits;
  localparam int W  = VB + 1;  // valid bit over value

  logic [10:0]   used_count;
  logic [NB-1:0] clr_idx;
  logic [NB-1:0] node;
  logic [NB:0]   ql, qr;
  logic          upd_ok;
  rmm_pkg::value_t upd_val;
  logic [W-1:0]  left_word;
  logic [W-1:0]  left_max;
  logic          any;
  rmm_pkg::value_t lo, hi;
  logic          pick_l;

  logic [NB-1:0] addr;
  logic          we;
  logic [W-1:0]  wmin, wmax, rmin, rmax;
  logic [W-1:0]  fmin, fmax;

  logic [11:0]   cnt;
  logic [11:0]   first_c, last_c;

  // cap the count at capacity
  assign cnt = ({1'b0, used_count} > 12'(rmm_pkg::Capacity)) ? 12'(rmm_pkg::Capacity)
                                                             : {1'b0, used_count};
  assign first_c = (first_position == 11'd0) ? 12'd1 : {1'b0, first_position};
  assign last_c  = ({1'b0, last_position} > cnt) ? cnt : {1'b0, last_position};

  // hold config
  always_ff @(posedge clk) begin
    if (rst) begin
      used_count <= 11'(rmm_pkg::Capacity);
    end else if (cfg_we) begin
      used_count <= cfg_data;
    end
  end

  // combine children into parent words
  always_comb begin
    if (!left_word[VB] && !rmin[VB]) begin
      fmin = '0;
      fmax = '0;
    end else if (!left_word[VB]) begin
      fmin = rmin;
      fmax = rmax;
    end else if (!rmin[VB]) begin
      fmin = left_word;
      fmax = left_max;
    end else begin
      fmin = (left_word[VB-1:0] < rmin[VB-1:0]) ? left_word : rmin;
      fmax = (left_max[VB-1:0] > rmax[VB-1:0]) ? left_max : rmax;
    end
  end

  // drive memory port
  always_comb begin
    we = 1'b0;
    addr = node;
    wmin = '0;
    wmax = '0;
    if (ctrl.clear_write) begin
      we = 1'b1;
      addr = clr_idx;
    end else if (ctrl.leaf_write) begin
      we = 1'b1;
      wmin = {1'b1, upd_val};
      wmax = {1'b1, upd_val};
    end else if (ctrl.read_left) begin
      addr = {node[NB-1:1], 1'b0};
    end else if (ctrl.read_right) begin
      addr = {node[NB-1:1], 1'b1};
    end else if (ctrl.fix_write) begin
      we = 1'b1;
      addr = {1'b0, node[NB-1:1]};
      wmin = fmin;
      wmax = fmax;
    end else if (ctrl.qry_read) begin
      addr = pick_l ? ql[NB-1:0] : qr[NB-1:0] - NB'(1);
    end
  end

  rmm_ram #(.Width(W), .Depth(rmm_pkg::NodeCount)) u_min (
    .clk(clk), .we(we), .addr(addr), .wdata(wmin), .rdata(rmin));
  rmm_ram #(.Width(W), .Depth(rmm_pkg::NodeCount)) u_max (
    .clk(clk), .we(we), .addr(addr), .wdata(wmax), .rdata(rmax));

  // mark a result word
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctrl.result;
    end
  end

  // advance pointers and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (ctrl.clear_write) begin
      clr_idx <= clr_idx + NB'(1);
    end
    if (ctrl.load) begin
      upd_val <= value;
      upd_ok  <= (position != 11'd0) && ({1'b0, position} <= cnt);
      node    <= NB'(rmm_pkg::Capacity) + NB'(position) - NB'(1);
      ql      <= (NB+1)'(rmm_pkg::Capacity) + (NB+1)'(first_c) - (NB+1)'(1);
      qr      <= (first_c <= last_c) ? (NB+1)'(rmm_pkg::Capacity) + (NB+1)'(last_c)
                                     : (NB+1)'(rmm_pkg::Capacity);
      any     <= 1'b0;
      lo      <= '0;
      hi      <= '0;
    end
    if (ctrl.read_right) begin
      left_word <= rmin;
      left_max  <= rmax;
    end
    if (ctrl.climb) begin
      node <= {1'b0, node[NB-1:1]};
    end
    if (ctrl.qry_take) begin
      if (rmin[VB]) begin
        if (!any || rmin[VB-1:0] < lo) lo <= rmin[VB-1:0];
        if (!any || rmax[VB-1:0] > hi) hi <= rmax[VB-1:0];
        any <= 1'b1;
      end
      if (pick_l) begin
        ql <= ql + (NB+1)'(1);
      end else begin
        qr <= qr - (NB+1)'(1);
      end
    end
    if (ctrl.qry_shift) begin
      ql <= {1'b0, ql[NB:1]};
      qr <= {1'b0, qr[NB:1]};
    end
    if (ctrl.result) begin
      range_empty  <= !any;
      range_min    <= any ? lo : '0;
      range_max    <= any ? hi : '0;
      spread       <= any ? hi - lo : '0;
    end
  end

  assign pick_l = ql[0];
  assign stat.clear_last = (clr_idx == NB'(rmm_pkg::NodeCount - 1));
  assign stat.upd_ok     = upd_ok;
  assign stat.at_root    = (node == NB'(1));
  assign stat.qry_live   = ql < qr;
  assign stat.l_odd      = ql[0];
  assign stat.r_odd      = qr[0];
  assign stat.qry_pick_l = pick_l;
endmodule

/* rtl/range_min_max_spread_tree.sv */
// Query: climbs the tree level by level and reads each boundary node that it takes.
// Update: climbs the 10 tree levels, reading both children and writing the parent
// at each level through the one shared port of each tree memory.
// After reset, a clearing pass writes all 2048 node words with busy high.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// range_min_max_spread_tree
// Min and max segment trees with range query of min, max and spread.
// ----------------------------------------------------------------------------
module range_min_max_spread_tree (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [10:0] position,
  input  logic [30:0] value,
  input  logic [10:0] first_position,
  input  logic [10:0] last_position,
  input  logic        cfg_we,
  input  logic [10:0] cfg_data,
  output logic        result_valid,
  output logic [30:0] range_min,
  output logic [30:0] range_max,
  output logic [30:0] spread,
  output logic        range_empty
);
  rmm_pkg::ctrl_t ctrl;
  rmm_pkg::stat_t stat;

  rmm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .command(command),
    .stat(stat), .ctrl(ctrl), .busy(busy));

  rmm_dp u_dp (
    .clk(clk), .rst(rst), .ctrl(ctrl), .stat(stat),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .position(position), .value(value),
    .first_position(first_position), .last_position(last_position),
    .result_valid(result_valid), .range_min(range_min), .range_max(range_max),
    .spread(spread), .range_empty(range_empty));

  // check result fields agree
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (spread == range_max - range_min))
    else $error("spread mismatch");
  assert property (@(posedge clk) disable iff (rst)
    result_valid && range_empty |-> (range_min == '0 && range_max == '0))
    else $error("empty result not zero");
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> range_min <= range_max)
    else $error("min above max");
endmodule
